// ----- design/colp_pkg.sv -----
// shared constants, types and helpers for the circle outline overlay
package colp_pkg;

  // fixed point fraction bits of centre and radius
  localparam int FRAC = 8;
  // largest frame edge in pixels
  localparam logic [12:0] MAX_FRAME = 13'd4096;
  // radicand and root widths of the square root pipeline
  localparam int RAD_W  = 40;
  localparam int ROOT_W = 20;
  // one square root bit per stage
  localparam int SQ_N   = ROOT_W;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_RADIUS       = 3'd2,
    CFG_COLOUR       = 3'd3,
    CFG_FRAME_WIDTH  = 3'd4,
    CFG_FRAME_HEIGHT = 3'd5
  } cfg_idx_e;

  // q.8 value to whole pixel, half away from zero
  function automatic logic signed [21:0] round_px(input logic signed [21:0] v);
    logic signed [21:0] half;
    half = 22'sd1 <<< (FRAC - 1);
    if (v >= 0) begin
      round_px = (v + half) >>> FRAC;
    end else begin
      round_px = -((half - v) >>> FRAC);
    end
  endfunction

endpackage

// ----- design/colp_isqrt.sv -----
// two lane pipelined integer square root, one root bit per stage
module colp_isqrt #(
  parameter int TAG_W = 35
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          vld_i,
  input  logic [1:0][colp_pkg::RAD_W-1:0]               rad_i,
  input  logic [TAG_W-1:0]                              tag_i,
  output logic                                          vld_o,
  output logic [1:0][colp_pkg::ROOT_W-1:0]              root_o,
  output logic [TAG_W-1:0]                              tag_o
);

  localparam int N  = colp_pkg::SQ_N;
  localparam int RW = colp_pkg::RAD_W;
  localparam int QW = colp_pkg::ROOT_W;

  logic [N-1:0]             vld_q;
  logic [1:0][RW-1:0]       rem_q [N];
  logic [1:0][QW-1:0]       root_q [N];
  logic [TAG_W-1:0]         tag_q [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int B = N - 1 - s;
    logic               vld_in;
    logic [1:0][RW-1:0] rem_in;
    logic [1:0][QW-1:0] root_in;
    logic [TAG_W-1:0]   tag_in;
    logic [1:0][RW-1:0] rem_d;
    logic [1:0][QW-1:0] root_d;

    // stage input from the port or the previous stage
    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign tag_in  = tag_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign tag_in  = tag_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // try setting root bit B in each lane
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RW:0] trial;
      logic        ge;
      assign trial = ((RW+1)'(root_in[l]) << (B + 1)) | ((RW+1)'(1) << (2 * B));
      assign ge    = {1'b0, rem_in[l]} >= trial;
      assign rem_d[l]  = ge ? (rem_in[l] - trial[RW-1:0]) : rem_in[l];
      assign root_d[l] = ge ? (root_in[l] | (QW'(1) << B)) : root_in[l];
    end

    // valid bit of this stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    // payload of this stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        tag_q[s]  <= tag_in;
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign root_o = root_q[N-1];
  assign tag_o  = tag_q[N-1];

endmodule

// ----- design/circle_outline_pixel_overlay.sv -----
// Circle outline overlay: a pixel stream in, the same stream out with the
// pixels on a circle outline replaced by the colour register. One pixel is
// taken every clock while the output does not stall; each pixel passes one
// stage for the offsets and row band, one for the squares, one for the chord
// radicands, twenty for the one-bit-per-stage square root, one for the chord
// ends and one for the rounding compare and output register. A stall on the
// output side holds the whole pipeline. The user must write configuration
// registers only while no pixel is in flight; the block does not enforce it.
module circle_outline_pixel_overlay (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_in[7:0], col[19:8], row[31:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // pixel_out[7:0], on_circle[8], zero fill
);

  localparam int QW = colp_pkg::ROOT_W;
  localparam int RW = colp_pkg::RAD_W;
  localparam int TAG_W = 35;

  // configuration registers
  logic signed [19:0] cx_q, cy_q;
  logic [19:0]        r_q;
  logic [7:0]         colour_q;
  logic [12:0]        fw_q, fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      r_q      <= '0;
      colour_q <= 8'd255;
      fw_q     <= 13'd512;
      fh_q     <= 13'd512;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        colp_pkg::CFG_CENTER_X:     cx_q     <= cfg_data_i;
        colp_pkg::CFG_CENTER_Y:     cy_q     <= cfg_data_i;
        colp_pkg::CFG_RADIUS:       r_q      <= cfg_data_i;
        colp_pkg::CFG_COLOUR:       colour_q <= cfg_data_i[7:0];
        colp_pkg::CFG_FRAME_WIDTH:  fw_q     <= cfg_data_i[12:0];
        colp_pkg::CFG_FRAME_HEIGHT: fh_q     <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [7:0]  in_pix;
  logic [11:0] in_col, in_row;
  assign in_pix = s_axis_tdata[7:0];
  assign in_col = s_axis_tdata[19:8];
  assign in_row = s_axis_tdata[31:20];

  // stage 1: offsets from centre and row band
  logic signed [22:0] cx23, cy23, r23, lo, hi, dy_d, dx_d;
  logic [12:0]        w, h;
  logic               lo_ok, hi_ok, elig_d;

  always_comb begin
    cx23 = 23'(cx_q);
    cy23 = 23'(cy_q);
    r23  = $signed({3'b000, r_q});
    dy_d = $signed({3'b000, in_row, 8'h00}) - cy23;
    dx_d = $signed({3'b000, in_col, 8'h00}) - cx23;
    lo   = cy23 - r23 - 23'sd512;
    hi   = cy23 + r23 + 23'sd512;
    w    = (fw_q > colp_pkg::MAX_FRAME) ? colp_pkg::MAX_FRAME : fw_q;
    h    = (fh_q > colp_pkg::MAX_FRAME) ? colp_pkg::MAX_FRAME : fh_q;
    lo_ok = lo[22] || (15'(in_row) >= lo[22:8]);
    if (hi[22]) begin
      hi_ok = 1'b0;
    end else if (hi[22:8] >= 15'(h)) begin
      hi_ok = (15'(in_row) + 15'd1) < 15'(h);
    end else begin
      hi_ok = 15'(in_row) < hi[22:8];
    end
    elig_d = lo_ok && hi_ok && (13'(in_col) < w);
  end

  logic               v1_q, v2_q, v3_q;
  logic signed [22:0] dy1_q, dx1_q;
  logic               elig1_q, elig2_q, elig3_q;
  logic [7:0]         pix1_q, pix2_q, pix3_q;
  logic [11:0]        col1_q, col2_q, col3_q, row1_q, row2_q, row3_q;

  // stage 2: squares
  logic [21:0] ady, adx;
  logic [43:0] dy2_q, dx2_q;
  logic [39:0] r2_q;
  assign ady = dy1_q[22] ? 22'(-dy1_q) : 22'(dy1_q);
  assign adx = dx1_q[22] ? 22'(-dx1_q) : 22'(dx1_q);

  // stage 3: chord radicands
  logic [1:0][RW-1:0] rad_q;
  logic               oky3_q, okx3_q;

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // payload of the front stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      dy1_q   <= dy_d;
      dx1_q   <= dx_d;
      elig1_q <= elig_d;
      pix1_q  <= in_pix;
      col1_q  <= in_col;
      row1_q  <= in_row;
      dy2_q   <= 44'(ady) * 44'(ady);
      dx2_q   <= 44'(adx) * 44'(adx);
      r2_q    <= 40'(r_q) * 40'(r_q);
      elig2_q <= elig1_q;
      pix2_q  <= pix1_q;
      col2_q  <= col1_q;
      row2_q  <= row1_q;
      oky3_q  <= dy2_q <= 44'(r2_q);
      okx3_q  <= dx2_q <= 44'(r2_q);
      rad_q[0] <= r2_q - dy2_q[RW-1:0];
      rad_q[1] <= r2_q - dx2_q[RW-1:0];
      elig3_q <= elig2_q;
      pix3_q  <= pix2_q;
      col3_q  <= col2_q;
      row3_q  <= row2_q;
    end
  end

  // square roots of both chords
  logic                 vs;
  logic [1:0][QW-1:0]   root;
  logic [TAG_W-1:0]     tag_s;

  colp_isqrt #(.TAG_W(TAG_W)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v3_q),
    .rad_i  (rad_q),
    .tag_i  ({pix3_q, col3_q, row3_q, elig3_q, oky3_q, okx3_q}),
    .vld_o  (vs),
    .root_o (root),
    .tag_o  (tag_s)
  );

  // chord ends: row test uses the row chord, column test the column chord
  logic               v4_q;
  logic signed [21:0] xa_q, xb_q, ya_q, yb_q;
  logic [TAG_W-1:0]   tag4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q   <= 22'(cx_q) - $signed({2'b00, root[0]});
      xb_q   <= 22'(cx_q) + $signed({2'b00, root[0]});
      ya_q   <= 22'(cy_q) - $signed({2'b00, root[1]});
      yb_q   <= 22'(cy_q) + $signed({2'b00, root[1]});
      tag4_q <= tag_s;
    end
  end

  // rounding, compare and output register
  logic [7:0]         pix4;
  logic signed [21:0] col4, row4;
  logic               hit;
  logic [7:0]         pix_out_q;
  logic               on_q;

  always_comb begin
    pix4 = tag4_q[34:27];
    col4 = $signed({10'd0, tag4_q[26:15]});
    row4 = $signed({10'd0, tag4_q[14:3]});
    hit  = tag4_q[1] && ((colp_pkg::round_px(xa_q) == col4) ||
                         (colp_pkg::round_px(xb_q) == col4));
    hit  = hit || (tag4_q[0] && ((colp_pkg::round_px(ya_q) == row4) ||
                                 (colp_pkg::round_px(yb_q) == row4)));
    hit  = hit && tag4_q[TAG_W-1-8-24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_out_q <= hit ? colour_q : pix4;
      on_q      <= hit;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, on_q, pix_out_q};

  // a replaced pixel carries the outline colour
  a_on_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && on_q) |-> (pix_out_q == colour_q))
    else $error("replaced pixel differs from colour");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> (out_vld_q && $stable(pix_out_q) && $stable(on_q)))
    else $error("stalled result changed");

  // input is refused only behind a waiting result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_vld_q && !m_axis_tready))
    else $error("input refused without output stall");

endmodule

// ----- bench/circle_outline_pixel_overlay_tb.sv -----
// testbench for the circle outline overlay: self-checking stream test with its own predictor
`timescale 1ns / 1ps

module circle_outline_pixel_overlay_tb;

  localparam int LATENCY = 25;

  typedef struct packed {
    logic [7:0] pixel;
    logic       hit;
  } overlay_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // predictor's copy of the registers
  logic [19:0] cx_q = '0;
  logic [19:0] cy_q = '0;
  logic [19:0] rad_q = '0;
  logic [7:0]  colour_q = 8'd255;
  logic [12:0] fw_q = 13'd512;
  logic [12:0] fh_q = 13'd512;

  overlay_res_t expected_pixels[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  circle_outline_pixel_overlay dut (.*);

  always #10 clk_i = ~clk_i;

  // integer square root of a 64 bit value
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint to_px_trunc(input longint v);
    if (v >= 0) return v >>> colp_pkg::FRAC;
    return -((-v) >>> colp_pkg::FRAC);
  endfunction

  function automatic longint to_px_round(input longint v);
    longint half;
    half = 64'sd1 <<< (colp_pkg::FRAC - 1);
    if (v >= 0) return (v + half) >>> colp_pkg::FRAC;
    return -((half - v) >>> colp_pkg::FRAC);
  endfunction

  // chord half length in q.8, -1 when the offset is outside the circle
  function automatic longint chord_half(input longint unsigned r2, input longint d);
    longint unsigned ad;
    ad = (d < 0) ? -d : d;
    if (ad * ad > r2) return -1;
    return longint'(int_sqrt(r2 - ad * ad));
  endfunction

  function automatic overlay_res_t overlay_pixel(input logic [7:0] pix, input logic [11:0] c,
                                                 input logic [11:0] r);
    longint cx, cy, rr, w, h, ymin, ymax, s, one, col, row;
    longint unsigned r2;
    overlay_res_t o;
    logic hit;
    one = 64'sd1 <<< colp_pkg::FRAC;
    cx = longint'($signed(cx_q));
    cy = longint'($signed(cy_q));
    rr = longint'(rad_q);
    r2 = rr * rr;
    col = c;
    row = r;
    w = (fw_q > colp_pkg::MAX_FRAME) ? 4096 : fw_q;
    h = (fh_q > colp_pkg::MAX_FRAME) ? 4096 : fh_q;
    ymin = to_px_trunc(cy - rr - 2 * one);
    ymax = to_px_trunc(cy + rr + 2 * one);
    hit = 1'b0;
    if (ymin < 0) ymin = 0;
    if (ymax >= h) ymax = h - 1;
    if (row >= ymin && row < ymax && col < w) begin
      s = chord_half(r2, row * one - cy);
      if (s >= 0 && (to_px_round(cx - s) == col || to_px_round(cx + s) == col)) hit = 1'b1;
      s = chord_half(r2, col * one - cx);
      if (s >= 0 && (to_px_round(cy - s) == row || to_px_round(cy + s) == row)) hit = 1'b1;
    end
    o.pixel = hit ? colour_q : pix;
    o.hit = hit;
    return o;
  endfunction

  // register write while idle, predictor copy follows
  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      colp_pkg::CFG_CENTER_X:     cx_q = val;
      colp_pkg::CFG_CENTER_Y:     cy_q = val;
      colp_pkg::CFG_RADIUS:       rad_q = val;
      colp_pkg::CFG_COLOUR:       colour_q = val[7:0];
      colp_pkg::CFG_FRAME_WIDTH:  fw_q = val[12:0];
      colp_pkg::CFG_FRAME_HEIGHT: fh_q = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_circle(input logic [19:0] cx, input logic [19:0] cy,
                            input logic [19:0] r, input logic [7:0] col,
                            input logic [12:0] fw, input logic [12:0] fh);
    write_reg(colp_pkg::CFG_CENTER_X, cx);
    write_reg(colp_pkg::CFG_CENTER_Y, cy);
    write_reg(colp_pkg::CFG_RADIUS, r);
    write_reg(colp_pkg::CFG_COLOUR, {12'd0, col});
    write_reg(colp_pkg::CFG_FRAME_WIDTH, {7'd0, fw});
    write_reg(colp_pkg::CFG_FRAME_HEIGHT, {7'd0, fh});
  endtask

  // one pixel request, called and returning at a falling edge
  // valid stays up for the next request; drain drops it
  task automatic send_pixel(input logic [7:0] pix, input logic [11:0] c, input logic [11:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, c, pix};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.push_back(overlay_pixel(pix, c, r));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  // pixels near the outline, mostly, with some anywhere
  task automatic random_pixels(input int n);
    int cxp, cyp, rp, c, r;
    for (int i = 0; i < n; i++) begin
      cxp = $signed(cx_q) >>> colp_pkg::FRAC;
      cyp = $signed(cy_q) >>> colp_pkg::FRAC;
      rp = rad_q >> colp_pkg::FRAC;
      if ($urandom_range(3) == 0) begin
        c = $urandom_range(4095);
        r = $urandom_range(4095);
      end else begin
        c = cxp + $signed($urandom_range(2 * rp + 6)) - rp - 3;
        r = cyp + $signed($urandom_range(2 * rp + 6)) - rp - 3;
        if ($urandom_range(1)) r = cyp + ($urandom_range(1) ? rp : -rp) +
                                   $signed($urandom_range(2)) - 1;
      end
      send_pixel(8'($urandom_range(255)), c[11:0], r[11:0]);
    end
  endtask

  task automatic test_directed();
    set_circle(20'd6400, 20'd5120, 20'd2560, 8'd200, 13'd64, 13'd64);
    send_pixel(8'h00, 12'd35, 12'd20);
    send_pixel(8'hff, 12'd15, 12'd20);
    send_pixel(8'h5a, 12'd25, 12'd30);
    send_pixel(8'ha5, 12'd25, 12'd10);
    send_pixel(8'h11, 12'd25, 12'd20);
    send_pixel(8'h22, 12'd4095, 12'd4095);
    send_pixel(8'h33, 12'd0, 12'd0);
    send_pixel(8'h44, 12'd64, 12'd20);
    drain();
    // empty band and zero width
    set_circle(20'h80000, 20'h80000, 20'd0, 8'd0, 13'd0, 13'd0);
    send_pixel(8'h01, 12'd0, 12'd0);
    send_pixel(8'hfe, 12'd4095, 12'd0);
    drain();
    // oversized frame, widest extremes
    set_circle(20'h7ffff, 20'h7ffff, 20'hfffff, 8'd1, 13'h1fff, 13'h1fff);
    send_pixel(8'h77, 12'd4095, 12'd4095);
    send_pixel(8'h78, 12'd0, 12'd2047);
    send_pixel(8'h79, 12'd2047, 12'd0);
    drain();
    // centre at zero with small radius, frame of one pixel
    set_circle(20'd0, 20'd0, 20'd128, 8'd9, 13'd1, 13'd1);
    send_pixel(8'h80, 12'd0, 12'd0);
    send_pixel(8'h81, 12'd1, 12'd0);
    drain();
    // unknown index is ignored
    write_reg(3'd6, 20'hfffff);
    write_reg(3'd7, 20'h12345);
    set_circle(20'd896, 20'd896, 20'd896, 8'd77, 13'd16, 13'd16);
    for (int i = 0; i < 8; i++) send_pixel(8'hc0, i[11:0], 12'd0);
    drain();
  endtask

  task automatic test_random(input int sp, input int rp, input int n);
    int cx, cy, r;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int k = 0; k < 8; k++) begin
      r = (k % 4 == 0) ? $urandom_range(20'hfffff) : $urandom_range(60 * 256);
      cx = $urandom_range(200 * 256) - 20 * 256;
      cy = $urandom_range(200 * 256) - 20 * 256;
      if (k == 3) cx = $urandom_range(20'hfffff);
      set_circle(cx[19:0], cy[19:0], r[19:0], 8'($urandom_range(255)),
                 13'($urandom_range(13'h1fff)),
                 (k == 5) ? 13'd4096 : 13'($urandom_range(300)));
      random_pixels(n);
      drain();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_circle(20'd10240, 20'd10240, 20'd7757, 8'd3, 13'd128, 13'd128);
    hold_cycles = 300;
    random_pixels(120);
    drain();
  endtask

  // receiver ready with idling and long hold-offs
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checking
  always @(posedge clk_i) begin
    overlay_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_r = expected_pixels.pop_front();
        if (m_axis_tdata[7:0] !== exp_r.pixel || m_axis_tdata[8] !== exp_r.hit) begin
          $display("%0t: mismatch expected pixel %h hit %b, actual pixel %h hit %b",
                   $time, exp_r.pixel, exp_r.hit, m_axis_tdata[7:0], m_axis_tdata[8]);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(25, 54, 65);
    test_random(54, 25, 65);
    test_random(0, 0, 65);
    test_backpressure();
    drain();
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("[circle_outline_pixel_overlay] OK");
    end else begin
      $display("[circle_outline_pixel_overlay] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[circle_outline_pixel_overlay] ERROR");
    $finish;
  end

endmodule
